FILE: rtl/core/adrc_pkg.sv
// Shared types and constants for the audio dynamic range compressor.
// No dependencies; used by every module of the block.
package adrc_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 256;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned MAG_W      = 31;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Divider: dividend is the excess shifted left by ten, padded to an even width
  localparam int unsigned UNITY_SHIFT = 10;
  localparam int unsigned DIV_W       = 42;
  localparam int unsigned DIVISOR_W   = GAIN_W + 1;
  localparam int unsigned DIV_STEPS   = DIV_W / 2;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [DIVISOR_W-1:0] UNITY = DIVISOR_W'(1024);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [MAG_W-1:0]  THRESHOLD_RST = 31'h7FFF_FFFF;
  localparam logic [GAIN_W-1:0] RATIO_RST     = 16'd4096;
  localparam logic [GAIN_W-1:0] ATTACK_RST    = 16'd40;
  localparam logic [GAIN_W-1:0] RELEASE_RST   = 16'd40;

  typedef struct packed {
    logic [MAG_W-1:0]  threshold;
    logic [GAIN_W-1:0] ratio_x1024;
    logic [GAIN_W-1:0] attack_step;
    logic [GAIN_W-1:0] release_step;
  } cfg_t;

  // Classified request passed from the front end to the back end
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             negative;
    logic             last;
  } item_t;

endpackage

FILE: rtl/core/audio_dynamic_range_compressor.sv
// Audio dynamic range compressor with a moving-average level detector. Samples
// enter through a queue-style push/full port and results leave through
// empty/pop. A sample passes the back end's idle, sum, gain, check and out
// states, plus a divide state when its magnitude is above the threshold with
// a nonzero gain; the iterative divider forms two quotient bits per cycle. Up to
// two samples wait in the front queue and one finished result is held in the
// output register. The magnitude history needs no clearing pass after reset.
// Configuration writes are always ready and should be made while idle.
// Depends on adrc_pkg, adrc_front and adrc_back.
module audio_dynamic_range_compressor #(
  parameter int unsigned HISTORY_DEPTH = adrc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [adrc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [adrc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [adrc_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic                                  block_last_i,
  input  logic                                  pop,
  output logic                                  empty,
  output logic signed [adrc_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic [adrc_pkg::MAG_W-1:0]            peak_mag_o,
  output logic [adrc_pkg::GAIN_W-1:0]           gain_x1024_o
);

  adrc_pkg::cfg_t  cfg_q;
  adrc_pkg::item_t q_item;
  logic            q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= adrc_pkg::THRESHOLD_RST;
      cfg_q.ratio_x1024  <= adrc_pkg::RATIO_RST;
      cfg_q.attack_step  <= adrc_pkg::ATTACK_RST;
      cfg_q.release_step <= adrc_pkg::RELEASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        adrc_pkg::CFG_THRESHOLD:
          cfg_q.threshold <= cfg_data_i[adrc_pkg::MAG_W-1:0];
        adrc_pkg::CFG_RATIO:
          cfg_q.ratio_x1024 <= cfg_data_i[adrc_pkg::GAIN_W-1:0];
        adrc_pkg::CFG_ATTACK_STEP:
          cfg_q.attack_step <= cfg_data_i[adrc_pkg::GAIN_W-1:0];
        adrc_pkg::CFG_RELEASE_STEP:
          cfg_q.release_step <= cfg_data_i[adrc_pkg::GAIN_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  adrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .sample_in_i  (sample_in_i),
    .block_last_i (block_last_i),
    .full_o       (full),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  adrc_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .sample_out_o (sample_out_o),
    .peak_mag_o   (peak_mag_o),
    .gain_x1024_o (gain_x1024_o)
  );

endmodule

FILE: rtl/core/adrc_front.sv
// Front end: accepts samples, forms the saturated magnitude, and queues them.
// Depends on adrc_pkg.
module adrc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic signed [adrc_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                              block_last_i,
  output logic                              full_o,
  output logic                              q_valid_o,
  output adrc_pkg::item_t                   q_item_o,
  input  logic                              q_pop_i
);

  logic [adrc_pkg::SAMPLE_W-1:0] abs_val;
  adrc_pkg::item_t               new_item;
  adrc_pkg::item_t               slot_q [2];
  logic                          wr_ptr_q, rd_ptr_q;
  logic [1:0]                    cnt_q;
  logic                          do_push, do_pop;

  always_comb begin
    abs_val           = ~sample_in_i + adrc_pkg::SAMPLE_W'(1);
    new_item.negative = sample_in_i[adrc_pkg::SAMPLE_W-1];
    new_item.last     = block_last_i;
    if (!sample_in_i[adrc_pkg::SAMPLE_W-1]) begin
      new_item.mag = sample_in_i[adrc_pkg::MAG_W-1:0];
    end else if (abs_val[adrc_pkg::SAMPLE_W-1]) begin
      // most negative input saturates
      new_item.mag = '1;
    end else begin
      new_item.mag = abs_val[adrc_pkg::MAG_W-1:0];
    end
  end

  assign full_o    = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("front queue count out of range");

endmodule

FILE: rtl/core/adrc_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Depends on adrc_pkg.
module adrc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [adrc_pkg::DIV_W-1:0]         dividend_i,
  input  logic [adrc_pkg::DIVISOR_W-1:0]     divisor_i,
  output logic                               done_o,
  output logic [adrc_pkg::MAG_W-1:0]         quotient_o
);

  logic                              busy_q, done_q;
  logic [adrc_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [adrc_pkg::DIVISOR_W-1:0]    div_q, rem_q, rem_d;
  logic [adrc_pkg::DIV_W-1:0]        quo_q, quo_d;

  always_comb begin
    logic [adrc_pkg::DIVISOR_W:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_d, quo_d[adrc_pkg::DIV_W-1]};
      quo_d = {quo_d[adrc_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial    = trial - {1'b0, div_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[adrc_pkg::DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= adrc_pkg::DIV_CNT_W'(adrc_pkg::DIV_STEPS - 1);
        div_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - adrc_pkg::DIV_CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[adrc_pkg::MAG_W-1:0];

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < div_q) else $error("divider remainder not below divisor");

endmodule

FILE: rtl/core/adrc_back.sv
// Back end: magnitude history, running sum, gain tracking, knee reduction,
// peak tracking and the result register. Depends on adrc_pkg and adrc_div.
module adrc_back #(
  parameter int unsigned HISTORY_DEPTH = adrc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  adrc_pkg::cfg_t                        cfg_i,
  input  logic                                  q_valid_i,
  input  adrc_pkg::item_t                       q_item_i,
  output logic                                  q_pop_o,
  input  logic                                  pop_i,
  output logic                                  empty_o,
  output logic signed [adrc_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic [adrc_pkg::MAG_W-1:0]            peak_mag_o,
  output logic [adrc_pkg::GAIN_W-1:0]           gain_x1024_o
);

  localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SUM_W = adrc_pkg::MAG_W + $clog2(HISTORY_DEPTH);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_C  = SUM_W'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    B_IDLE, B_SUM, B_GAIN, B_CHECK, B_DIV, B_OUT
  } state_e;

  state_e                          state_q;
  adrc_pkg::item_t                 item_q;
  logic [PTR_W-1:0]                pos_q;
  logic                            wrapped_q;
  logic [SUM_W-1:0]                sum_q, thr_mul_q, old_mag;
  logic [adrc_pkg::MAG_W-1:0]      rd_q, res_mag_q, peak_q, new_peak;
  logic [adrc_pkg::GAIN_W-1:0]     gain_q, gain_d;
  logic [adrc_pkg::GAIN_W:0]       gain_sum;
  logic                            out_valid_q, out_we, mem_we, mem_re;
  logic signed [adrc_pkg::SAMPLE_W-1:0] sample_q;
  logic [adrc_pkg::MAG_W-1:0]      peak_out_q;
  logic [adrc_pkg::GAIN_W-1:0]     gain_out_q;
  logic                            div_start, div_done;
  logic [adrc_pkg::MAG_W-1:0]      excess, quotient;

  logic [adrc_pkg::MAG_W-1:0]      hist_mem [HISTORY_DEPTH];

  assign mem_re  = (state_q == B_IDLE) && q_valid_i;
  assign q_pop_o = mem_re;
  assign mem_we  = (state_q == B_SUM);
  assign out_we  = (state_q == B_OUT) && (!out_valid_q || pop_i);
  // unwritten entries read as zero until the ring has gone round once
  assign old_mag = wrapped_q ? SUM_W'(rd_q) : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[pos_q] <= item_q.mag;
    end
    if (mem_re) begin
      rd_q <= hist_mem[pos_q];
    end
  end

  always_comb begin
    gain_sum = {1'b0, gain_q} + {1'b0, cfg_i.attack_step};
    gain_d   = gain_q;
    if (sum_q > thr_mul_q) begin
      if (gain_q < cfg_i.ratio_x1024) begin
        gain_d = (gain_sum > {1'b0, cfg_i.ratio_x1024}) ? cfg_i.ratio_x1024
                                                        : gain_sum[adrc_pkg::GAIN_W-1:0];
      end
    end else if (gain_q != '0) begin
      gain_d = (cfg_i.release_step >= gain_q) ? '0 : gain_q - cfg_i.release_step;
    end
  end

  assign excess    = item_q.mag - cfg_i.threshold;
  assign div_start = (state_q == B_CHECK) && (gain_q != '0) &&
                     (item_q.mag > cfg_i.threshold);
  assign new_peak  = (res_mag_q > peak_q) ? res_mag_q : peak_q;

  adrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({{(adrc_pkg::DIV_W - adrc_pkg::MAG_W - adrc_pkg::UNITY_SHIFT){1'b0}},
                  excess, {adrc_pkg::UNITY_SHIFT{1'b0}}}),
    .divisor_i  (adrc_pkg::UNITY + {1'b0, gain_q}),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      item_q      <= '0;
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      sum_q       <= '0;
      thr_mul_q   <= '0;
      gain_q      <= '0;
      peak_q      <= '0;
      res_mag_q   <= '0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      peak_out_q  <= '0;
      gain_out_q  <= '0;
    end else begin
      // a new result written in the same cycle keeps the register full
      if (pop_i && out_valid_q && !out_we) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            item_q    <= q_item_i;
            thr_mul_q <= SUM_W'(cfg_i.threshold) * DEPTH_C;
            state_q   <= B_SUM;
          end
        end
        B_SUM: begin
          sum_q <= sum_q - old_mag + SUM_W'(item_q.mag);
          if (pos_q == LAST_POS) begin
            pos_q     <= '0;
            wrapped_q <= 1'b1;
          end else begin
            pos_q <= pos_q + PTR_W'(1);
          end
          state_q <= B_GAIN;
        end
        B_GAIN: begin
          gain_q  <= gain_d;
          state_q <= B_CHECK;
        end
        B_CHECK: begin
          if (div_start) begin
            state_q <= B_DIV;
          end else begin
            res_mag_q <= item_q.mag;
            state_q   <= B_OUT;
          end
        end
        B_DIV: begin
          if (div_done) begin
            res_mag_q <= cfg_i.threshold + quotient;
            state_q   <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_we) begin
            out_valid_q <= 1'b1;
            sample_q    <= item_q.negative
                           ? -$signed({1'b0, res_mag_q})
                           : $signed({1'b0, res_mag_q});
            peak_out_q  <= new_peak;
            gain_out_q  <= gain_q;
            peak_q      <= item_q.last ? '0 : new_peak;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign empty_o      = !out_valid_q;
  assign sample_out_o = sample_q;
  assign peak_mag_o   = peak_out_q;
  assign gain_x1024_o = gain_out_q;

  a_div_needs_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> gain_q != '0) else $error("division started with zero gain");

  a_no_expansion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_we |-> res_mag_q <= item_q.mag) else $error("output magnitude above input");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == B_DIV) else $error("divider result outside divide state");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == B_OUT) else $error("result without write");

endmodule

FILE: test/adrc_checker.sv
// Result checker for audio_dynamic_range_compressor: tracks register writes and accepted
// samples, predicts each compressed result and compares it with what the block pops.
// Depends on adrc_pkg.
`timescale 1ns / 100ps
module adrc_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [adrc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [adrc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 push_i,
  input  logic                                 full_i,
  input  logic signed [adrc_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                                 block_last_i,
  input  logic                                 pop_i,
  input  logic                                 empty_i,
  input  logic signed [adrc_pkg::SAMPLE_W-1:0] sample_out_i,
  input  logic [adrc_pkg::MAG_W-1:0]           peak_mag_i,
  input  logic [adrc_pkg::GAIN_W-1:0]          gain_x1024_i,
  output int unsigned                          mismatches_o,
  output int unsigned                          pending_o
);

  localparam int unsigned DEPTH = adrc_pkg::HISTORY_DEPTH_DEF;
  localparam int unsigned POS_W = $clog2(DEPTH);
  localparam logic [adrc_pkg::MAG_W-1:0] MAG_MAX = '1;

  typedef struct packed {
    logic signed [adrc_pkg::SAMPLE_W-1:0] sample_out;
    logic [adrc_pkg::MAG_W-1:0]           peak_mag;
    logic [adrc_pkg::GAIN_W-1:0]          gain_x1024;
  } result_t;

  adrc_pkg::cfg_t                         cfg;
  logic [adrc_pkg::MAG_W-1:0]             mag_ring [DEPTH];
  logic [adrc_pkg::MAG_W+POS_W-1:0]       ring_sum;
  logic [POS_W-1:0]                       ring_pos;
  logic [adrc_pkg::GAIN_W-1:0]            gain;
  logic [adrc_pkg::MAG_W-1:0]             peak;
  result_t                                expected_results[$];
  int unsigned                            mismatches = 0;

  function automatic result_t compress_sample(input logic [adrc_pkg::SAMPLE_W-1:0] raw,
                                              input logic last);
    logic                          negative;
    logic [adrc_pkg::SAMPLE_W-1:0] flipped;
    logic [adrc_pkg::MAG_W-1:0]    mag;
    logic [adrc_pkg::GAIN_W:0]     raised;
    longint unsigned               excess;
    longint unsigned               quotient;
    result_t                       r;
    negative = raw[adrc_pkg::SAMPLE_W-1];
    flipped  = -raw;
    // only -2^31 flips to a value with the top bit still set
    if (negative) mag = flipped[adrc_pkg::SAMPLE_W-1] ? MAG_MAX
                                                      : flipped[adrc_pkg::MAG_W-1:0];
    else          mag = raw[adrc_pkg::MAG_W-1:0];

    ring_sum = ring_sum - mag_ring[ring_pos] + mag;
    mag_ring[ring_pos] = mag;

    if (ring_sum > longint'(cfg.threshold) * DEPTH) begin
      // a gain already above a lowered cap just holds
      if (gain < cfg.ratio_x1024) begin
        raised = gain + cfg.attack_step;
        gain = (raised > cfg.ratio_x1024) ? cfg.ratio_x1024
                                          : raised[adrc_pkg::GAIN_W-1:0];
      end
    end else if (gain != '0) begin
      gain = (cfg.release_step >= gain) ? '0 : gain - cfg.release_step;
    end

    if (gain != '0 && mag > cfg.threshold) begin
      excess   = longint'(mag - cfg.threshold) * longint'(adrc_pkg::UNITY);
      quotient = excess / (longint'(adrc_pkg::UNITY) + gain);
      mag      = cfg.threshold + adrc_pkg::MAG_W'(quotient);
    end

    if (mag > peak) peak = mag;

    r.sample_out = negative ? -{1'b0, mag} : {1'b0, mag};
    r.peak_mag   = peak;
    r.gain_x1024 = gain;

    ring_pos = (ring_pos == POS_W'(DEPTH - 1)) ? '0 : ring_pos + 1'b1;
    if (last) peak = '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t predicted;
    if (!rst_ni) begin
      cfg.threshold    = adrc_pkg::THRESHOLD_RST;
      cfg.ratio_x1024  = adrc_pkg::RATIO_RST;
      cfg.attack_step  = adrc_pkg::ATTACK_RST;
      cfg.release_step = adrc_pkg::RELEASE_RST;
      foreach (mag_ring[i]) mag_ring[i] = '0;
      ring_sum = '0;
      ring_pos = '0;
      gain     = '0;
      peak     = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          adrc_pkg::CFG_THRESHOLD:
            cfg.threshold    = cfg_data_i[adrc_pkg::MAG_W-1:0];
          adrc_pkg::CFG_RATIO:
            cfg.ratio_x1024  = cfg_data_i[adrc_pkg::GAIN_W-1:0];
          adrc_pkg::CFG_ATTACK_STEP:
            cfg.attack_step  = cfg_data_i[adrc_pkg::GAIN_W-1:0];
          adrc_pkg::CFG_RELEASE_STEP:
            cfg.release_step = cfg_data_i[adrc_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end

      // pop before push: a result popped now cannot belong to a request taken now
      if (pop_i && !empty_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("result popped with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (sample_out_i !== want.sample_out) begin
            mismatches++;
            $error("sample_out: expected %0d, got %0d", want.sample_out, sample_out_i);
          end
          if (peak_mag_i !== want.peak_mag) begin
            mismatches++;
            $error("peak_mag: expected %0d, got %0d", want.peak_mag, peak_mag_i);
          end
          if (gain_x1024_i !== want.gain_x1024) begin
            mismatches++;
            $error("gain_x1024: expected %0d, got %0d", want.gain_x1024, gain_x1024_i);
          end
        end
      end

      if (push_i && !full_i) begin
        predicted = compress_sample(sample_in_i, block_last_i);
        expected_results.push_back(predicted);
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_results.size();
  end

endmodule

FILE: test/audio_dynamic_range_compressor_tb.sv
// Testbench top for audio_dynamic_range_compressor: drives register writes and samples
// with random gaps and one long receiver hold-off; checking lives in adrc_checker.
// Depends on adrc_pkg, adrc_checker and the block itself.
`timescale 1ns / 100ps
module audio_dynamic_range_compressor_tb;

  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned QUIET_PHASE     = 2;
  localparam int unsigned IDLE_PERCENT    = 29;
  localparam int unsigned HOLD_OFF_AT     = 200;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES     = 64;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam logic [adrc_pkg::MAG_W-1:0]     MAG_MAX       = '1;
  localparam logic [adrc_pkg::CFG_IDX_W-1:0] CFG_INDEX_TOP = '1;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  logic [adrc_pkg::CFG_IDX_W-1:0]       cfg_index_i;
  logic [adrc_pkg::CFG_DATA_W-1:0]      cfg_data_i;
  logic                                 push;
  logic                                 full;
  logic signed [adrc_pkg::SAMPLE_W-1:0] sample_in_i;
  logic                                 block_last_i;
  logic                                 pop;
  logic                                 empty;
  logic signed [adrc_pkg::SAMPLE_W-1:0] sample_out_o;
  logic [adrc_pkg::MAG_W-1:0]           peak_mag_o;
  logic [adrc_pkg::GAIN_W-1:0]          gain_x1024_o;

  int unsigned mismatches;
  int unsigned pending;
  logic        rx_gaps;
  bit          tx_gaps;
  int unsigned samples_sent = 0;
  int unsigned reg_writes   = 0;
  int unsigned settings     = 0;

  audio_dynamic_range_compressor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .sample_in_i  (sample_in_i),
    .block_last_i (block_last_i),
    .pop          (pop),
    .empty        (empty),
    .sample_out_o (sample_out_o),
    .peak_mag_o   (peak_mag_o),
    .gain_x1024_o (gain_x1024_o)
  );

  adrc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .full_i       (full),
    .sample_in_i  (sample_in_i),
    .block_last_i (block_last_i),
    .pop_i        (pop),
    .empty_i      (empty),
    .sample_out_i (sample_out_o),
    .peak_mag_i   (peak_mag_o),
    .gain_x1024_i (gain_x1024_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Slowest correct run is roughly 620 samples plus the hold-off, about 60 us;
  // this allows ten times that.
  initial begin
    #600_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: random pop gaps, plus one long hold-off so the block backs up
  initial begin
    int unsigned popped;
    bit          held;
    popped = 0;
    held   = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) popped++;
      if (!held && popped == HOLD_OFF_AT) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        pop <= rx_gaps ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
      end
    end
  end

  // Leaves cfg_valid_i high; end_config lowers it once the batch is done.
  task automatic write_reg(input logic [adrc_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [adrc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
  endtask

  task automatic end_config();
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // Leaves push high so back-to-back requests need no gap.
  task automatic send_sample(input logic [adrc_pkg::SAMPLE_W-1:0] s, input logic last);
    while (tx_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    sample_in_i  <= s;
    block_last_i <= last;
    do @(posedge clk_i); while (full);
    samples_sent++;
  endtask

  // The checker's count is registered, hence the edge before the first look.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [adrc_pkg::SAMPLE_W-1:0] pick_sample(
      input logic [adrc_pkg::MAG_W-1:0] thr);
    logic [adrc_pkg::MAG_W-1:0]    m;
    logic [adrc_pkg::SAMPLE_W-1:0] s;
    m = '0;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       s = '0;
          1:       s = {1'b0, MAG_MAX};
          2:       s = {1'b1, {adrc_pkg::MAG_W{1'b0}}};
          default: s = '1;
        endcase
        return s;
      end
      1, 2, 3, 4: return $urandom();
      5, 6, 7: m = thr + adrc_pkg::MAG_W'($urandom_range(0, 4095))
                   - adrc_pkg::MAG_W'(2048);
      default: m = adrc_pkg::MAG_W'($urandom_range(0, 65535));
    endcase
    return $urandom_range(0, 1) ? -{1'b0, m} : {1'b0, m};
  endfunction

  function automatic logic [adrc_pkg::GAIN_W-1:0] pick_gain_setting();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return adrc_pkg::GAIN_W'($urandom_range(1, 512));
      default: return adrc_pkg::GAIN_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [adrc_pkg::MAG_W-1:0]      thr;
    logic [adrc_pkg::CFG_DATA_W-1:0] data;
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    push         <= 1'b0;
    sample_in_i  <= '0;
    block_last_i <= 1'b0;
    rx_gaps      <= 1'b1;
    tx_gaps      = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: threshold at full scale, so the gain never moves
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);   // most negative input saturates
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    wait_drained();

    // Bit 31 of the threshold write is dropped, leaving zero; caps and steps at maximum
    write_reg(adrc_pkg::CFG_THRESHOLD, adrc_pkg::CFG_DATA_W'(1) << adrc_pkg::MAG_W);
    write_reg(adrc_pkg::CFG_RATIO, 32'hFFFF_FFFF);
    write_reg(adrc_pkg::CFG_ATTACK_STEP, 32'h0000_FFFF);
    write_reg(adrc_pkg::CFG_RELEASE_STEP, 32'hABCD_FFFF);
    write_reg(CFG_INDEX_TOP, $urandom());   // unused index, ignored
    end_config();
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(-32'sd5, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    wait_drained();

    // Cap lowered beneath the running gain: it holds while the level stays high
    write_reg(adrc_pkg::CFG_THRESHOLD, 32'd1000);
    write_reg(adrc_pkg::CFG_RATIO, 32'd2048);
    end_config();
    send_sample(32'h4000_0000, 1'b0);
    send_sample(-32'sh4000_0000, 1'b0);
    wait_drained();

    // Level no longer above a full-scale threshold: gain releases down to zero
    write_reg(adrc_pkg::CFG_THRESHOLD, {1'b0, MAG_MAX});
    write_reg(adrc_pkg::CFG_RELEASE_STEP, 32'd20000);
    end_config();
    repeat (4) send_sample(32'h4000_0000, 1'b0);
    wait_drained();

    // Zero attack keeps the gain at zero, so nothing above the knee is reduced
    write_reg(adrc_pkg::CFG_THRESHOLD, 32'd100);
    write_reg(adrc_pkg::CFG_RATIO, 32'd4096);
    write_reg(adrc_pkg::CFG_ATTACK_STEP, 32'd0);
    write_reg(adrc_pkg::CFG_RELEASE_STEP, 32'd0);
    end_config();
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(-32'sd5000, 1'b0);
    send_sample(32'h0010_0000, 1'b1);
    wait_drained();

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0:       thr = '0;
        1:       thr = MAG_MAX;
        2:       thr = adrc_pkg::MAG_W'($urandom_range(0, 1 << 20));
        default: thr = adrc_pkg::MAG_W'($urandom_range(1 << 28, 1 << 30));
      endcase
      data = $urandom();
      data[adrc_pkg::MAG_W-1:0] = thr;
      write_reg(adrc_pkg::CFG_THRESHOLD, data);
      data = $urandom();
      data[adrc_pkg::GAIN_W-1:0] = pick_gain_setting();
      write_reg(adrc_pkg::CFG_RATIO, data);
      data = $urandom();
      data[adrc_pkg::GAIN_W-1:0] = pick_gain_setting();
      write_reg(adrc_pkg::CFG_ATTACK_STEP, data);
      data = $urandom();
      data[adrc_pkg::GAIN_W-1:0] = pick_gain_setting();
      write_reg(adrc_pkg::CFG_RELEASE_STEP, data);
      if ($urandom_range(0, 1))
        write_reg(adrc_pkg::CFG_IDX_W'($urandom_range(adrc_pkg::CFG_RELEASE_STEP + 1,
                                                      CFG_INDEX_TOP)), $urandom());
      end_config();

      // one phase runs flat out on both sides
      tx_gaps = (ph != QUIET_PHASE);
      rx_gaps <= (ph != QUIET_PHASE);
      repeat (ITEMS_PER_PHASE) send_sample(pick_sample(thr), $urandom_range(0, 15) == 0);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d samples checked over %0d register settings (%0d writes),",
             samples_sent, settings, reg_writes);
    $display("including saturation, cap, attack/release extremes and a full-queue stall");
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
